>>> src/pqldf_pkg.sv
package pqldf_pkg;

    // table geometry
    localparam int SUBSPACES   = 16;
    localparam int CENTROIDS   = 8;
    localparam int TABLE_DEPTH = SUBSPACES * CENTROIDS;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);

    // field widths fixed by the interface
    localparam int CMD_W   = 2;
    localparam int SUB_W   = 4;
    localparam int CEN_W   = 8;
    localparam int DATA_W  = 32;
    localparam int ROW_W   = 24;
    localparam int SCALE_W = 16;
    localparam int CFG_IDX_W = 1;

    // command codes
    localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_THRESH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CODE   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_SCALE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTER_SCALE = 1'b1;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd16384;

    // quotient d*2^16/r2 is 48 bits wide, one bit per divider step
    localparam int QUOT_W    = 48;
    localparam int DIV_STEPS = QUOT_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [QUOT_W-1:0] Q_ONE = 48'h0000_0001_0000;
    localparam logic [DATA_W-1:0] SAT32 = 32'hFFFF_FFFF;

    // entry pipeline sequencer, one-hot
    typedef enum logic [6:0] {
        S_IDLE  = 7'b000_0001,
        S_DIV   = 7'b000_0010,
        S_SCALE = 7'b000_0100,
        S_TERM  = 7'b000_1000,
        S_SQR   = 7'b001_0000,
        S_PLO   = 7'b010_0000,
        S_PHI   = 7'b100_0000
    } t_state;

endpackage

>>> src/pq_lookup_distance_filter_top.sv
// Product-quantization distance estimator with pruning, unsigned Q16.16.
//
// Input channel (i_in_valid / o_in_ready) takes one command per transfer:
//   table write  - corrects a raw subspace distance by the centroid radius
//                  and stores it in the 128-entry distance table,
//   threshold    - sets the pruning bound,
//   row code     - adds one table entry to the running row sum; the code
//                  flagged last_code sends row id, estimate and pass flag.
// Output channel (o_out_valid / i_out_ready) is one result register.
// Row codes stream at one per cycle while no table write is in progress:
// the table is read at the transfer, the sum is updated on the next cycle,
// then the last code's sum goes to the result register. A table write with
// nonzero distance and radius runs the bit-serial 48-step divider and the
// scale, term, square and two partial-product multiply steps, the last three
// skipped when the factor overflows; zero distance, zero radius and threshold
// writes finish at the transfer. While a result waits for the receiver,
// other codes still flow; a last code waits until the result register drains.
// Reset clears the sum, sets the bound to all ones and both scales to 1.0;
// the table contents are undefined until written. Config writes (i_cfg_we)
// are registered and are meant for idle periods.
module pq_lookup_distance_filter_top
    import pqldf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SCALE_W-1:0]   i_cfg_data,

    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [CMD_W-1:0]     i_cmd,
    input  logic [SUB_W-1:0]     i_subspace,
    input  logic [CEN_W-1:0]     i_centroid,
    input  logic [DATA_W-1:0]    i_raw_distance,
    input  logic [DATA_W-1:0]    i_radius_squared,
    input  logic [DATA_W-1:0]    i_threshold,
    input  logic [ROW_W-1:0]     i_row_id,
    input  logic                 i_last_code,

    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [ROW_W-1:0]     o_row_id_out,
    output logic [DATA_W-1:0]    o_estimate,
    output logic                 o_passes
);

    // distance table
    logic [DATA_W-1:0] r_table [TABLE_DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // control
    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [SCALE_W-1:0] r_inner, r_outer;
    logic [DATA_W-1:0] r_bound;
    logic [DATA_W-1:0] r_sum;
    logic              r_s2_valid;
    logic              r_s2_last;
    logic              r_s2_in_range;
    logic              r_out_valid;

    // payload
    logic [ROW_W-1:0]  r_s2_row;
    logic [ADDR_W-1:0] r_addr;
    logic [DATA_W-1:0] r_d;
    logic [DATA_W-1:0] r_r2;
    logic [DATA_W-1:0] r_rem;
    logic [QUOT_W-1:0] r_q;
    logic              r_gt;
    logic [49:0]       r_p;
    logic [DATA_W-1:0] r_t;
    logic [47:0]       r_t2;
    logic [55:0]       r_plo;
    logic [ROW_W-1:0]  r_out_row;
    logic [DATA_W-1:0] r_out_est;
    logic              r_out_pass;

    // input decode
    logic              w_acc;
    logic              w_in_range;
    logic [ADDR_W-1:0] w_in_addr;
    logic              w_hold_last;

    assign w_in_range = (32'(i_subspace) < SUBSPACES) && (32'(i_centroid) < CENTROIDS);
    assign w_in_addr  = w_in_range ?
                        ADDR_W'(32'(i_subspace) * CENTROIDS + 32'(i_centroid)) : '0;

    // a last code needs the result register free when its sum lands
    assign w_hold_last = (i_cmd == CMD_CODE) && i_last_code &&
                         (r_out_valid || (r_s2_valid && r_s2_last));
    assign o_in_ready  = (r_state == S_IDLE) && !w_hold_last;
    assign w_acc       = i_in_valid && o_in_ready;

    // divider step
    logic [DATA_W:0] w_trial, w_diff;
    logic            w_ge;
    assign w_trial = {r_rem, r_q[QUOT_W-1]};
    assign w_diff  = w_trial - {1'b0, r_r2};
    assign w_ge    = w_trial >= {1'b0, r_r2};

    // scale step: p = s * |v - 1| >> 14
    logic        w_gt;
    logic [16:0] w_diff_lo;
    logic [47:0] w_diff_hi;
    logic [15:0] w_mul_a;
    logic [47:0] w_mul_b;
    logic [63:0] w_prod;
    assign w_gt      = r_q > Q_ONE;
    assign w_diff_lo = Q_ONE[16:0] - r_q[16:0];
    assign w_diff_hi = r_q - Q_ONE;
    assign w_mul_a   = w_gt ? r_outer : r_inner;
    assign w_mul_b   = w_gt ? w_diff_hi : 48'(w_diff_lo);
    assign w_prod    = 64'(w_mul_a) * 64'(w_mul_b);

    // term t
    logic [50:0] w_p_ext, w_t;
    logic        w_t_ovf;
    assign w_p_ext = 51'(r_p);
    always_comb begin
        if (r_gt) begin
            w_t = 51'(Q_ONE) + w_p_ext;
        end else if (w_p_ext >= 51'(Q_ONE)) begin
            w_t = w_p_ext - 51'(Q_ONE);
        end else begin
            w_t = 51'(Q_ONE) - w_p_ext;
        end
    end
    assign w_t_ovf = w_t[50:32] != '0;

    // square and final product
    logic [63:0] w_sq;
    logic [55:0] w_plo;
    logic [79:0] w_phi, w_full;
    logic [DATA_W-1:0] w_entry;
    assign w_sq    = 64'(r_t) * 64'(r_t);
    assign w_plo   = 56'(r_d) * 56'(r_t2[23:0]);
    assign w_phi   = 80'(r_d) * 80'(r_t2[47:24]);
    assign w_full  = (w_phi << 24) + 80'(r_plo);
    assign w_entry = (w_full[79:48] != '0) ? SAT32 : w_full[47:16];

    // table write port
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [DATA_W-1:0] w_wdata;
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_addr;
        w_wdata = w_entry;
        if (w_acc && (i_cmd == CMD_WRITE) && w_in_range) begin
            if (i_radius_squared == '0) begin
                w_we    = 1'b1;
                w_waddr = w_in_addr;
                w_wdata = SAT32;
            end else if (i_raw_distance == '0) begin
                w_we    = 1'b1;
                w_waddr = w_in_addr;
                w_wdata = '0;
            end
        end else if ((r_state == S_TERM) && w_t_ovf) begin
            w_we    = 1'b1;
            w_wdata = SAT32;
        end else if (r_state == S_PHI) begin
            w_we    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_table[w_waddr] <= w_wdata;
        end
        r_rdata <= r_table[w_in_addr];
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc && (i_cmd == CMD_WRITE) && w_in_range &&
                    (i_radius_squared != '0) && (i_raw_distance != '0)) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: n_state = S_TERM;
            S_TERM:  n_state = w_t_ovf ? S_IDLE : S_SQR;
            S_SQR:   n_state = S_PLO;
            S_PLO:   n_state = S_PHI;
            S_PHI:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // sum stage
    logic [DATA_W:0]   w_sum_full;
    logic [DATA_W-1:0] w_sum_sat;
    assign w_sum_full = {1'b0, r_sum} +
                        {1'b0, (r_s2_in_range ? r_rdata : {DATA_W{1'b0}})};
    assign w_sum_sat  = w_sum_full[DATA_W] ? SAT32 : w_sum_full[DATA_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_inner     <= SCALE_RESET;
            r_outer     <= SCALE_RESET;
            r_bound     <= SAT32;
            r_sum       <= '0;
            r_s2_valid  <= 1'b0;
            r_s2_last   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (r_state == S_DIV) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_INNER_SCALE: r_inner <= i_cfg_data;
                    CFG_OUTER_SCALE: r_outer <= i_cfg_data;
                    default: ;
                endcase
            end

            if (w_acc && (i_cmd == CMD_THRESH)) begin
                r_bound <= i_threshold;
            end

            r_s2_valid <= w_acc && (i_cmd == CMD_CODE);
            r_s2_last  <= w_acc && (i_cmd == CMD_CODE) && i_last_code;

            if (r_s2_valid) begin
                r_sum <= r_s2_last ? '0 : w_sum_sat;
            end

            if (r_s2_valid && r_s2_last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s2_row      <= i_row_id;
            r_s2_in_range <= w_in_range;
        end

        if (w_acc && (i_cmd == CMD_WRITE)) begin
            r_addr <= w_in_addr;
            r_d    <= i_raw_distance;
            r_r2   <= i_radius_squared;
            r_rem  <= '0;
            r_q    <= {i_raw_distance, 16'h0000};
        end else if (r_state == S_DIV) begin
            r_rem <= w_ge ? w_diff[DATA_W-1:0] : w_trial[DATA_W-1:0];
            r_q   <= {r_q[QUOT_W-2:0], w_ge};
        end

        if (r_state == S_SCALE) begin
            r_gt <= w_gt;
            r_p  <= w_prod[63:14];
        end
        if (r_state == S_TERM) begin
            r_t <= w_t[DATA_W-1:0];
        end
        if (r_state == S_SQR) begin
            r_t2 <= w_sq[63:16];
        end
        if (r_state == S_PLO) begin
            r_plo <= w_plo;
        end

        if (r_s2_valid && r_s2_last) begin
            r_out_row  <= r_s2_row;
            r_out_est  <= w_sum_sat;
            r_out_pass <= w_sum_sat < r_bound;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_row_id_out = r_out_row;
    assign o_estimate   = r_out_est;
    assign o_passes     = r_out_pass;

    // a finishing row never meets an occupied result register
    a_last_finds_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid && r_s2_last |-> !r_out_valid)
        else $error("row result would overwrite a pending result");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_cnt < CNT_W'(DIV_STEPS))
        else $error("divider ran past its step count");

    a_phi_writes_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PHI |=> r_state == S_IDLE)
        else $error("entry pipeline did not return to idle after table write");

    a_sum_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid && r_s2_last |=> r_sum == '0)
        else $error("running sum not cleared after last code");

    a_no_table_race: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !(w_acc && (i_cmd == CMD_CODE)))
        else $error("code read accepted while a table entry is in flight");

endmodule
